// ===== src/rmft_pkg.sv =====
package rmft_pkg;

    localparam int NUM_IDS    = 1024;
    localparam int COUNT_BITS = 32;

    localparam int ID_BITS    = 10;
    localparam int DELTA_BITS = 17;
    localparam int OUT_BITS   = 32;
    localparam int NODE_BITS  = $clog2(NUM_IDS) + 1;
    localparam int SUM_BITS   = ((COUNT_BITS > DELTA_BITS) ? COUNT_BITS : DELTA_BITS) + 2;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [NODE_BITS-1:0]  t_node;

    function automatic logic [OUT_BITS-1:0] out_clamp(input t_count v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[OUT_BITS-1:0];
    endfunction

endpackage

// ===== src/rmft_ram.sv =====
module rmft_ram #(
    parameter int ADDR_BITS = 11,
    parameter int WIDTH     = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/rmft_sat_add.sv =====
module rmft_sat_add
    import rmft_pkg::*;
(
    input  t_count                       i_count,
    input  logic signed [DELTA_BITS-1:0] i_delta,
    output t_count                       o_count,
    output logic                         o_sat
);

    logic signed [SUM_BITS-1:0] w_sum;

    assign w_sum = $signed({{(SUM_BITS-COUNT_BITS){1'b0}}, i_count}) + SUM_BITS'(i_delta);

    always_comb begin
        if (w_sum[SUM_BITS-1]) begin
            o_count = '0;
            o_sat   = 1'b1;
        end else if (w_sum[SUM_BITS-2:COUNT_BITS] != '0) begin
            o_count = '1;
            o_sat   = 1'b1;
        end else begin
            o_count = w_sum[COUNT_BITS-1:0];
            o_sat   = 1'b0;
        end
    end

endmodule

// ===== src/running_max_frequency_table.sv =====
// Frequency counter with running maximum. Each input beat carries an id and a signed
// delta; the id's count is updated with saturation at zero and at full scale, and the
// output beat returns the largest count over all ids together with a flag set when the
// update was clamped. Counts and the tournament tree of maxima share one single-port-read,
// single-port-write memory indexed as a heap (root at 1, leaves at NUM_IDS + id). For an
// item, the leaf is read at acceptance, the leaf state updates and writes it back, one
// read-compare-write per tree level follows, and the final state loads the output
// register. The next input beat is accepted in the cycle after the result is loaded, so
// the block takes no new item while one is in progress; while the output register is
// still full the block holds its result and accepts no input. After reset a clearing
// pass writes every one of the 2 * NUM_IDS entries, during which no input beat is
// accepted.
module running_max_frequency_table
    import rmft_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,   // id [9:0], delta [26:10]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_BITS-1:0] m_axis_tdata,   // max_count [31:0]
    output logic                m_axis_tuser    // saturated [0]
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEAF,
        ST_WALK,
        ST_FIN
    } t_state;

    t_state                       r_state;
    t_node                        r_clr;
    t_node                        r_node;
    t_count                       r_val;
    t_count                       r_root;
    logic                         r_sat;
    logic signed [DELTA_BITS-1:0] r_delta;
    logic                         r_out_valid;
    logic [OUT_BITS-1:0]          r_out_data;
    logic                         r_out_user;

    logic [ID_BITS-1:0]           w_id;
    logic signed [DELTA_BITS-1:0] w_delta;
    t_node                        w_leaf;
    logic                         w_in_range;
    t_node                        w_parent;
    t_count                       w_rdata;
    t_count                       w_max;
    t_count                       w_new;
    logic                         w_new_sat;
    logic                         w_we;
    t_node                        w_waddr;
    t_count                       w_wdata;
    t_node                        w_raddr;
    logic                         w_accept;
    logic                         w_load;

    assign w_id       = s_axis_tdata[ID_BITS-1:0];
    assign w_delta    = $signed(s_axis_tdata[ID_BITS+DELTA_BITS-1:ID_BITS]);
    assign w_leaf     = NODE_BITS'(NUM_IDS) + NODE_BITS'(w_id);
    assign w_in_range = 32'(w_id) < NUM_IDS;
    assign w_parent   = r_node >> 1;
    assign w_max      = (w_rdata > r_val) ? w_rdata : r_val;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_load     = (r_state == ST_FIN) && (!r_out_valid || m_axis_tready);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    rmft_sat_add u_sat_add (
        .i_count (w_rdata),
        .i_delta (r_delta),
        .o_count (w_new),
        .o_sat   (w_new_sat)
    );

    rmft_ram #(
        .ADDR_BITS (NODE_BITS),
        .WIDTH     (COUNT_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = '0;
        w_raddr = w_leaf;
        case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
            end
            ST_LEAF: begin
                w_we    = 1'b1;
                w_waddr = r_node;
                w_wdata = w_new;
                w_raddr = r_node ^ t_node'(1);
            end
            ST_WALK: begin
                w_we    = 1'b1;
                w_waddr = w_parent;
                w_wdata = w_max;
                w_raddr = w_parent ^ t_node'(1);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + t_node'(1);
                    if (r_clr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_node  <= w_leaf;
                        r_delta <= w_delta;
                        if (w_in_range) begin
                            r_state <= ST_LEAF;
                        end else begin
                            r_sat   <= 1'b0;
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_LEAF: begin
                    r_val   <= w_new;
                    r_sat   <= w_new_sat;
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    r_val  <= w_max;
                    r_node <= w_parent;
                    if (w_parent == t_node'(1)) begin
                        r_root  <= w_max;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // hold until the output register is free
                    if (w_load) begin
                        r_out_data  <= out_clamp(r_root);
                        r_out_user  <= r_sat;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
